[design/bcds_pkg.sv]
// Shared types and constants for the back-face cull and depth bucket sort block.
// No dependencies; imported by backface_cull_depth_bucket_sort and its testbench.
package bcds_pkg;

    localparam int COORD_W = 16;
    localparam int DEPTH_W = 16;
    localparam int SUM_W   = 18;
    localparam int TIDX_W  = 12;
    localparam int KEPT_W  = 13;

    typedef enum logic [1:0] {
        ST_SORTED  = 2'd0,
        ST_ENTRY   = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AREA1,
        S_AREA2,
        S_STORE,
        S_CLEAR,
        S_MM_RD,
        S_MM_USE,
        S_BIN_RD,
        S_BIN_CHK,
        S_DIV_LOAD,
        S_DIV,
        S_BC_RD,
        S_BC_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_RD_FETCH,
        S_RD_OUT,
        S_DONE
    } state_t;

endpackage

[design/backface_cull_depth_bucket_sort.sv]
// Top level of the back-face cull and depth bucket sort block.
// Depends on bcds_pkg for field widths, status codes and the sequencer states.

// A load word passes through the area states and a store before the next word
// is accepted; a load over capacity and every read word return their result
// word on done. A load marked last runs the sort before its result word: it
// clears the bin counters, scans the loaded triangles for the depth range,
// bins the kept triangles in two passes and forms the prefix sum between
// them. The binning cost comes from the single shared multiplier and the
// one-bit-per-cycle divider that forms each bin. busy stays high for the
// whole of that time. Results are presented for exactly one cycle with done
// high and cannot be held off by the receiver.
module backface_cull_depth_bucket_sort #(
    parameter int MAX_TRIANGLES = 4096,
    parameter int DEPTH_BINS    = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                opcode,
    input  logic signed [bcds_pkg::COORD_W-1:0] ax,
    input  logic signed [bcds_pkg::COORD_W-1:0] ay,
    input  logic signed [bcds_pkg::COORD_W-1:0] bx,
    input  logic signed [bcds_pkg::COORD_W-1:0] by_coord,
    input  logic signed [bcds_pkg::COORD_W-1:0] cx,
    input  logic signed [bcds_pkg::COORD_W-1:0] cy,
    input  logic        [bcds_pkg::DEPTH_W-1:0] az,
    input  logic        [bcds_pkg::DEPTH_W-1:0] bz,
    input  logic        [bcds_pkg::DEPTH_W-1:0] cz,
    input  logic                                last_triangle,
    output logic [1:0]                          status,
    output logic [bcds_pkg::TIDX_W-1:0]         triangle_index,
    output logic [bcds_pkg::KEPT_W-1:0]         kept_count,
    output logic                                last_in_order
);
    import bcds_pkg::*;

    localparam int ADDR_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CNT_W   = $clog2(MAX_TRIANGLES + 1);
    localparam int BA_W    = $clog2(DEPTH_BINS + 1);
    localparam int DB_W    = $clog2(DEPTH_BINS);
    localparam int BMUL_W  = (DB_W + 1 > COORD_W + 1) ? DB_W + 1 : COORD_W + 1;
    localparam int MA_W    = SUM_W + 1;
    localparam int PROD_W  = MA_W + BMUL_W;
    localparam int NUM_W   = SUM_W + DB_W;
    localparam int DC_W    = $clog2(NUM_W + 1);

    // Sequencer and datapath registers.
    state_t                    state_reg, state_next;
    logic                      reading_reg, reading_next;
    logic [CNT_W-1:0]          loaded_reg, loaded_next;
    logic [CNT_W-1:0]          front_reg, front_next;
    logic [SUM_W-1:0]          near_reg, near_next;
    logic [SUM_W-1:0]          far_reg, far_next;
    logic [CNT_W-1:0]          rpos_reg, rpos_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [BA_W-1:0]           bptr_reg, bptr_next;
    logic [BA_W-1:0]           bin_reg, bin_next;
    logic [CNT_W-1:0]          acc_reg, acc_next;
    logic                      pass2_reg, pass2_next;
    logic [DC_W-1:0]           dcnt_reg, dcnt_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [SUM_W-1:0]          rem_reg, rem_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  p1_reg, p1_next;
    status_t                   st_reg, st_next;
    logic [ADDR_W-1:0]         tidx_reg, tidx_next;
    logic                      lio_reg, lio_next;

    // Latched input word.
    logic                      last_in_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [DEPTH_W-1:0]        az_reg, bz_reg, cz_reg;

    // Memories.
    logic [SUM_W:0]            tri_mem [MAX_TRIANGLES];
    logic [CNT_W-1:0]          bin_mem [DEPTH_BINS + 1];
    logic [ADDR_W-1:0]         ord_mem [MAX_TRIANGLES];
    logic [SUM_W:0]            tri_rd_reg;
    logic [CNT_W-1:0]          bin_rd_reg;
    logic [ADDR_W-1:0]         ord_rd_reg;

    // Memory and multiplier controls.
    logic                      tri_we;
    logic [ADDR_W-1:0]         tri_addr;
    logic [SUM_W:0]            tri_wdata;
    logic                      bin_we;
    logic [BA_W-1:0]           bin_addr;
    logic [CNT_W-1:0]          bin_wdata;
    logic                      ord_we;
    logic [ADDR_W-1:0]         ord_waddr;
    logic [ADDR_W-1:0]         ord_raddr;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [BMUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // Combinational helpers.
    logic signed [COORD_W:0]   dx1, dy1, dx2, dy2;
    logic [SUM_W-1:0]          sum_in;
    logic [SUM_W-1:0]          rd_sum;
    logic                      rd_front;
    logic [SUM_W-1:0]          range_w;
    logic [SUM_W:0]            trial;
    logic [BA_W-1:0]           bin_clamped;
    logic [CNT_W-1:0]          loaded_eff;
    logic [31:0]               tidx_ext;
    logic [31:0]               kept_ext;

    assign dx1 = {bx_reg[COORD_W-1], bx_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign dy1 = {cy_reg[COORD_W-1], cy_reg} - {ay_reg[COORD_W-1], ay_reg};
    assign dx2 = {cx_reg[COORD_W-1], cx_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign dy2 = {by_reg[COORD_W-1], by_reg} - {ay_reg[COORD_W-1], ay_reg};
    assign sum_in = SUM_W'(az_reg) + SUM_W'(bz_reg) + SUM_W'(cz_reg);
    assign rd_sum = tri_rd_reg[SUM_W-1:0];
    assign rd_front = tri_rd_reg[SUM_W];
    assign range_w = far_reg - near_reg;
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign bin_clamped = (num_reg > NUM_W'(DEPTH_BINS - 1)) ? BA_W'(DEPTH_BINS - 1)
                                                            : num_reg[BA_W-1:0];
    assign loaded_eff = reading_reg ? '0 : loaded_reg;
    assign mul_p = mul_a * mul_b;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode)
                    begin
                        if (reading_reg && (rpos_reg < front_reg))
                            state_next = S_RD_FETCH;
                        else
                            state_next = S_DONE;
                    end
                    else if (loaded_eff < CNT_W'(MAX_TRIANGLES))
                        state_next = S_AREA1;
                    else if (last_triangle)
                        state_next = S_CLEAR;
                    else
                        state_next = S_DONE;
                end
            end
            S_AREA1:    state_next = S_AREA2;
            S_AREA2:    state_next = S_STORE;
            S_STORE:    state_next = last_in_reg ? S_CLEAR : S_IDLE;
            S_CLEAR:
            begin
                if (bptr_reg == BA_W'(DEPTH_BINS))
                    state_next = S_MM_RD;
            end
            S_MM_RD:
            begin
                if (idx_reg == loaded_reg)
                    state_next = (front_reg == '0) ? S_DONE : S_BIN_RD;
                else
                    state_next = S_MM_USE;
            end
            S_MM_USE:   state_next = S_MM_RD;
            S_BIN_RD:
            begin
                if (idx_reg == loaded_reg)
                    state_next = pass2_reg ? S_DONE : S_PFX_RD;
                else
                    state_next = S_BIN_CHK;
            end
            S_BIN_CHK:
            begin
                if (!rd_front)
                    state_next = S_BIN_RD;
                else if (range_w == '0)
                    state_next = S_BC_RD;
                else
                    state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (dcnt_reg == DC_W'(NUM_W - 1))
                    state_next = S_BC_RD;
            end
            S_BC_RD:    state_next = S_BC_WR;
            S_BC_WR:    state_next = S_BIN_RD;
            S_PFX_RD:   state_next = S_PFX_WR;
            S_PFX_WR:
            begin
                if (bptr_reg == BA_W'(DEPTH_BINS))
                    state_next = S_BIN_RD;
                else
                    state_next = S_PFX_RD;
            end
            S_RD_FETCH: state_next = S_RD_OUT;
            S_RD_OUT:   state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        reading_next = reading_reg;
        loaded_next  = loaded_reg;
        front_next   = front_reg;
        near_next    = near_reg;
        far_next     = far_reg;
        rpos_next    = rpos_reg;
        idx_next     = idx_reg;
        bptr_next    = bptr_reg;
        bin_next     = bin_reg;
        acc_next     = acc_reg;
        pass2_next   = pass2_reg;
        dcnt_next    = dcnt_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        prod_next    = prod_reg;
        p1_next      = p1_reg;
        st_next      = st_reg;
        tidx_next    = tidx_reg;
        lio_next     = lio_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    tidx_next = '0;
                    lio_next  = 1'b0;
                    bptr_next = '0;
                    if (opcode)
                        st_next = ST_EMPTY;
                    else
                    begin
                        if (reading_reg)
                        begin
                            reading_next = 1'b0;
                            loaded_next  = '0;
                            rpos_next    = '0;
                        end
                        st_next = (loaded_eff < CNT_W'(MAX_TRIANGLES)) ? ST_SORTED
                                                                       : ST_DROPPED;
                    end
                end
            end
            S_AREA1:    prod_next = mul_p;
            S_AREA2:
            begin
                p1_next   = prod_reg;
                prod_next = mul_p;
            end
            S_STORE:    loaded_next = loaded_reg + 1'b1;
            S_CLEAR:
            begin
                bptr_next = bptr_reg + 1'b1;
                front_next = '0;
                near_next  = '0;
                far_next   = '0;
                idx_next   = '0;
            end
            S_MM_RD:
            begin
                if (idx_reg == loaded_reg)
                begin
                    idx_next   = '0;
                    pass2_next = 1'b0;
                    if (front_reg == '0)
                    begin
                        reading_next = 1'b1;
                        rpos_next    = '0;
                    end
                end
            end
            S_MM_USE:
            begin
                idx_next = idx_reg + 1'b1;
                if (rd_front)
                begin
                    front_next = front_reg + 1'b1;
                    if (front_reg == '0)
                    begin
                        near_next = rd_sum;
                        far_next  = rd_sum;
                    end
                    else
                    begin
                        if (rd_sum < near_reg)
                            near_next = rd_sum;
                        if (rd_sum > far_reg)
                            far_next = rd_sum;
                    end
                end
            end
            S_BIN_RD:
            begin
                if (idx_reg == loaded_reg)
                begin
                    if (pass2_reg)
                    begin
                        reading_next = 1'b1;
                        rpos_next    = '0;
                    end
                    else
                    begin
                        bptr_next = BA_W'(1);
                        acc_next  = '0;
                    end
                end
            end
            S_BIN_CHK:
            begin
                if (!rd_front)
                    idx_next = idx_reg + 1'b1;
                else if (range_w == '0)
                    num_next = '0;
                else
                    prod_next = mul_p;
            end
            S_DIV_LOAD:
            begin
                num_next  = prod_reg[NUM_W-1:0];
                rem_next  = '0;
                dcnt_next = '0;
            end
            S_DIV:
            begin
                dcnt_next = dcnt_reg + 1'b1;
                // Restoring division: the quotient bits fill num_reg from the bottom.
                if (trial >= {1'b0, range_w})
                begin
                    rem_next = SUM_W'(trial - {1'b0, range_w});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SUM_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
            end
            S_BC_RD:    bin_next = pass2_reg ? bin_clamped : bin_clamped + 1'b1;
            S_BC_WR:    idx_next = idx_reg + 1'b1;
            S_PFX_WR:
            begin
                acc_next  = acc_reg + bin_rd_reg;
                bptr_next = bptr_reg + 1'b1;
                if (bptr_reg == BA_W'(DEPTH_BINS))
                begin
                    idx_next   = '0;
                    pass2_next = 1'b1;
                end
            end
            S_RD_OUT:
            begin
                st_next   = ST_ENTRY;
                tidx_next = ord_rd_reg;
                lio_next  = (rpos_reg + 1'b1 == front_reg);
                rpos_next = rpos_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Memory and multiplier controls.
    always_comb
    begin
        tri_we    = 1'b0;
        tri_addr  = idx_reg[ADDR_W-1:0];
        tri_wdata = '0;
        bin_we    = 1'b0;
        bin_addr  = bptr_reg;
        bin_wdata = '0;
        ord_we    = 1'b0;
        ord_waddr = bin_rd_reg[ADDR_W-1:0];
        ord_raddr = rpos_reg[ADDR_W-1:0];
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_AREA1:
            begin
                mul_a = MA_W'(dx1);
                mul_b = BMUL_W'(dy1);
            end
            S_AREA2:
            begin
                mul_a = MA_W'(dx2);
                mul_b = BMUL_W'(dy2);
            end
            S_STORE:
            begin
                tri_we    = 1'b1;
                tri_addr  = loaded_reg[ADDR_W-1:0];
                tri_wdata = {(p1_reg > prod_reg), sum_in};
            end
            S_CLEAR:
            begin
                bin_we    = 1'b1;
                bin_wdata = '0;
            end
            S_BIN_CHK:
            begin
                mul_a = $signed({1'b0, far_reg - rd_sum});
                mul_b = BMUL_W'(DEPTH_BINS - 1);
            end
            S_BC_RD:    bin_addr = pass2_reg ? bin_clamped : bin_clamped + 1'b1;
            S_BC_WR:
            begin
                bin_addr  = bin_reg;
                bin_we    = 1'b1;
                bin_wdata = bin_rd_reg + 1'b1;
                ord_we    = pass2_reg;
            end
            S_PFX_WR:
            begin
                bin_we    = 1'b1;
                bin_wdata = acc_reg + bin_rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tri_we)
            tri_mem[tri_addr] <= tri_wdata;
        tri_rd_reg <= tri_mem[tri_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_addr] <= bin_wdata;
        bin_rd_reg <= bin_mem[bin_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_waddr] <= idx_reg[ADDR_W-1:0];
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            last_in_reg <= last_triangle;
            ax_reg <= ax;
            ay_reg <= ay;
            bx_reg <= bx;
            by_reg <= by_coord;
            cx_reg <= cx;
            cy_reg <= cy;
            az_reg <= az;
            bz_reg <= bz;
            cz_reg <= cz;
        end
        prod_reg <= prod_next;
        p1_reg   <= p1_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        bin_reg  <= bin_next;
        acc_reg  <= acc_next;
        tidx_reg <= tidx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            reading_reg <= 1'b0;
            loaded_reg  <= '0;
            front_reg   <= '0;
            near_reg    <= '0;
            far_reg     <= '0;
            rpos_reg    <= '0;
            idx_reg     <= '0;
            bptr_reg    <= '0;
            pass2_reg   <= 1'b0;
            dcnt_reg    <= '0;
            st_reg      <= ST_SORTED;
            lio_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            reading_reg <= reading_next;
            loaded_reg  <= loaded_next;
            front_reg   <= front_next;
            near_reg    <= near_next;
            far_reg     <= far_next;
            rpos_reg    <= rpos_next;
            idx_reg     <= idx_next;
            bptr_reg    <= bptr_next;
            pass2_reg   <= pass2_next;
            dcnt_reg    <= dcnt_next;
            st_reg      <= st_next;
            lio_reg     <= lio_next;
        end
    end

    assign tidx_ext       = 32'(tidx_reg);
    assign kept_ext       = 32'(front_reg);
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign status         = st_reg;
    assign triangle_index = tidx_ext[TIDX_W-1:0];
    assign kept_count     = kept_ext[KEPT_W-1:0];
    assign last_in_order  = lio_reg;

    // A result word always returns the block to idle on the next cycle.
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after a result word");

    // An order entry is only produced when some triangle was kept.
    a_entry_needs_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_ENTRY)) |-> (kept_count != '0))
        else $error("order entry with no kept triangles");

    // The nearest-triangle mark only rides on an order entry.
    a_last_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_in_order) |-> (status == ST_ENTRY))
        else $error("last_in_order set on a word that is not an order entry");

    // The read pointer never passes the kept count.
    a_rpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rpos_reg <= front_reg)
        else $error("read position beyond kept count");

endmodule

[tb/sv/tb_backface_cull_depth_bucket_sort.sv]
// Self-checking testbench for backface_cull_depth_bucket_sort: random meshes are loaded,
// sorted and read back, and every result word is compared with a built-in predictor.
// Depends on bcds_pkg and the backface_cull_depth_bucket_sort RTL.
`timescale 1ns / 1ps

module tb_backface_cull_depth_bucket_sort;
    import bcds_pkg::*;

    localparam int CAPACITY   = 4096;
    localparam int BIN_COUNT  = 2048;
    localparam int CYCLE_CAP  = 4000000;
    localparam bit OP_LOAD    = 1'b0;
    localparam bit OP_READ    = 1'b1;

    typedef struct {
        bit                        op;
        logic signed [COORD_W-1:0] ax, ay, bx, by_c, cx, cy;
        logic [DEPTH_W-1:0]        az, bz, cz;
        bit                        last;
    } mesh_word_t;

    typedef struct {
        status_t           st;
        logic [TIDX_W-1:0] idx;
        logic [KEPT_W-1:0] kept;
        bit                last;
    } order_result_t;

    // Holds its own copy of the mesh memories and predicts every result word.
    class order_board;
        int            sums[CAPACITY];
        bit            front[CAPACITY];
        int            order[CAPACITY];
        int            bin_fill[BIN_COUNT + 1];
        int            loaded, kept, nearest, farthest, read_pos;
        bit            reading;
        order_result_t pending_q[$];
        int            errors, sorts, entries, drops;

        function bit faces_viewer(mesh_word_t w);
            longint lhs, rhs;
            lhs = (longint'(w.bx) - longint'(w.ax)) * (longint'(w.cy) - longint'(w.ay));
            rhs = (longint'(w.cx) - longint'(w.ax)) * (longint'(w.by_c) - longint'(w.ay));
            return lhs > rhs;
        endfunction

        function int depth_bin(int s);
            longint b;
            if (farthest == nearest)
                return 0;
            b = (longint'(farthest - s) * (BIN_COUNT - 1)) / longint'(farthest - nearest);
            if (b > BIN_COUNT - 1)
                b = BIN_COUNT - 1;
            return int'(b);
        endfunction

        function void sort_mesh();
            int b;
            kept = 0;
            nearest = 0;
            farthest = 0;
            foreach (bin_fill[i])
                bin_fill[i] = 0;
            for (int i = 0; i < loaded; i++) begin
                if (front[i]) begin
                    if (kept == 0 || sums[i] < nearest)
                        nearest = sums[i];
                    if (kept == 0 || sums[i] > farthest)
                        farthest = sums[i];
                    kept++;
                end
            end
            if (kept == 0)
                return;
            for (int i = 0; i < loaded; i++)
                if (front[i])
                    bin_fill[depth_bin(sums[i]) + 1]++;
            for (int i = 1; i <= BIN_COUNT; i++)
                bin_fill[i] += bin_fill[i - 1];
            // Stable scatter: equal bins keep their load order.
            for (int i = 0; i < loaded; i++) begin
                if (front[i]) begin
                    b = depth_bin(sums[i]);
                    order[bin_fill[b]] = i;
                    bin_fill[b]++;
                end
            end
        endfunction

        function void push(status_t st, int idx, bit last);
            order_result_t r;
            r.st   = st;
            r.idx  = idx[TIDX_W-1:0];
            r.kept = kept[KEPT_W-1:0];
            r.last = last;
            pending_q.push_back(r);
        endfunction

        function void note_word(mesh_word_t w);
            bit dropped;
            dropped = 1'b0;
            if (w.op == OP_LOAD) begin
                if (reading) begin
                    reading  = 1'b0;
                    loaded   = 0;
                    read_pos = 0;
                end
                if (loaded < CAPACITY) begin
                    sums[loaded]  = int'(w.az) + int'(w.bz) + int'(w.cz);
                    front[loaded] = faces_viewer(w);
                    loaded++;
                end else begin
                    dropped = 1'b1;
                end
                if (w.last) begin
                    sort_mesh();
                    reading  = 1'b1;
                    read_pos = 0;
                    sorts++;
                    push(dropped ? ST_DROPPED : ST_SORTED, 0, 1'b0);
                end else if (dropped) begin
                    push(ST_DROPPED, 0, 1'b0);
                end
                if (dropped)
                    drops++;
            end else if (reading && read_pos < kept) begin
                push(ST_ENTRY, order[read_pos], read_pos + 1 == kept);
                read_pos++;
                entries++;
            end else begin
                push(ST_EMPTY, 0, 1'b0);
            end
        endfunction

        function void check_word(status_t st, logic [TIDX_W-1:0] idx,
                                 logic [KEPT_W-1:0] kc, logic last);
            order_result_t r;
            if (pending_q.size() == 0) begin
                $error("unexpected result word: status %0d index %0d", st, idx);
                errors++;
                return;
            end
            r = pending_q.pop_front();
            if (st !== r.st) begin
                $error("status: expected %0d, got %0d", r.st, st);
                errors++;
            end
            if (idx !== r.idx) begin
                $error("triangle_index: expected %0d, got %0d", r.idx, idx);
                errors++;
            end
            if (kc !== r.kept) begin
                $error("kept_count: expected %0d, got %0d", r.kept, kc);
                errors++;
            end
            if (last !== r.last) begin
                $error("last_in_order: expected %0d, got %0d", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        done;
    logic                        opcode;
    logic signed [COORD_W-1:0]   ax, ay, bx, by_coord, cx, cy;
    logic [DEPTH_W-1:0]          az, bz, cz;
    logic                        last_triangle;
    logic [1:0]                  status;
    logic [TIDX_W-1:0]           triangle_index;
    logic [KEPT_W-1:0]           kept_count;
    logic                        last_in_order;

    order_board board;
    int         cycles;
    int         words_sent;
    int         burst_left;

    backface_cull_depth_bucket_sort dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .opcode         (opcode),
        .ax             (ax),
        .ay             (ay),
        .bx             (bx),
        .by_coord       (by_coord),
        .cx             (cx),
        .cy             (cy),
        .az             (az),
        .bz             (bz),
        .cz             (cz),
        .last_triangle  (last_triangle),
        .status         (status),
        .triangle_index (triangle_index),
        .kept_count     (kept_count),
        .last_in_order  (last_in_order)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_word(status_t'(status), triangle_index, kept_count, last_in_order);
    end

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(mesh_word_t w);
        start         <= 1'b1;
        opcode        <= w.op;
        ax            <= w.ax;
        ay            <= w.ay;
        bx            <= w.bx;
        by_coord      <= w.by_c;
        cx            <= w.cx;
        cy            <= w.cy;
        az            <= w.az;
        bz            <= w.bz;
        cz            <= w.cz;
        last_triangle <= w.last;
        do
            @(posedge clk);
        while (busy);
        board.note_word(w);
        words_sent++;
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic mesh_word_t read_word();
        mesh_word_t w;
        w.op   = OP_READ;
        w.ax   = COORD_W'($urandom);
        w.ay   = COORD_W'($urandom);
        w.bx   = COORD_W'($urandom);
        w.by_c = COORD_W'($urandom);
        w.cx   = COORD_W'($urandom);
        w.cy   = COORD_W'($urandom);
        w.az   = DEPTH_W'($urandom);
        w.bz   = DEPTH_W'($urandom);
        w.cz   = DEPTH_W'($urandom);
        w.last = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic mesh_word_t tri_word(int ax_v, int ay_v, int bx_v, int by_v,
                                            int cx_v, int cy_v, int za, int zb, int zc,
                                            bit last);
        mesh_word_t w;
        w.op   = OP_LOAD;
        w.ax   = COORD_W'(ax_v);
        w.ay   = COORD_W'(ay_v);
        w.bx   = COORD_W'(bx_v);
        w.by_c = COORD_W'(by_v);
        w.cx   = COORD_W'(cx_v);
        w.cy   = COORD_W'(cy_v);
        w.az   = DEPTH_W'(za);
        w.bz   = DEPTH_W'(zb);
        w.cz   = DEPTH_W'(zc);
        w.last = last;
        return w;
    endfunction

    // Depth spreads vary per mesh so bins hit both
    // wide and very narrow depth ranges.
    function automatic mesh_word_t random_load(int depth_mode, int base, bit last);
        mesh_word_t w;
        w = read_word();
        w.op   = OP_LOAD;
        w.last = last;
        if ($urandom_range(0, 9) == 0) begin
            w.bx = w.ax;
            w.by_c = w.ay;
        end
        case (depth_mode)
            0: ;
            1: begin
                w.az = DEPTH_W'(base + $urandom_range(0, 3));
                w.bz = DEPTH_W'(base);
                w.cz = DEPTH_W'(base);
            end
            2: begin
                w.az = DEPTH_W'(base);
                w.bz = DEPTH_W'(base);
                w.cz = DEPTH_W'(base);
            end
            default: begin
                w.az = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                w.bz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                w.cz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
        endcase
        return w;
    endfunction

    initial
    begin
        int mesh_size, depth_mode, base, extra;

        board      = new();
        words_sent = 0;
        burst_left = 0;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        opcode        <= OP_LOAD;
        ax            <= '0;
        ay            <= '0;
        bx            <= '0;
        by_coord      <= '0;
        cx            <= '0;
        cy            <= '0;
        az            <= '0;
        bz            <= '0;
        cz            <= '0;
        last_triangle <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: read before any sort, extreme coordinates and depths,
        // back-facing and zero-area triangles, an all-culled mesh, equal sums.
        send_word(read_word());
        send_word(tri_word(-32768, -32768, 32767, -32768, -32768, 32767,
                           65535, 65535, 65535, 1'b0));
        send_word(tri_word(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0, 0, 1'b0));
        send_word(tri_word(5, 5, 5, 5, 5, 5, 0, 0, 0, 1'b0));
        send_word(tri_word(0, 0, 100, 0, 0, 100, 256, 256, 256, 1'b1));
        repeat (3) send_word(read_word());
        send_word(tri_word(32767, 32767, 32767, 32767, -32768, -32768, 1, 2, 3, 1'b1));
        send_word(read_word());
        send_word(tri_word(0, 0, 40, 0, 0, 40, 300, 0, 0, 1'b0));
        send_word(tri_word(0, 0, 40, 0, 0, 40, 0, 300, 0, 1'b0));
        send_word(tri_word(0, 0, 40, 0, 0, 40, 0, 0, 300, 1'b1));
        repeat (4) send_word(read_word());
        send_word(tri_word(-9, 3, 7, -2, 1, 30, 65535, 65535, 0, 1'b1));
        send_word(read_word());
        send_word(tri_word(1, 1, 2, 1, 1, 2, 10, 10, 10, 1'b1));
        drain();

        // Random meshes: each is loaded, sorted and mostly read out, with
        // stray reads and early new meshes mixed in.
        while (words_sent < 1750) begin
            if (words_sent > 900 && words_sent < 940)
                drain();
            mesh_size  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(1, 16);
            depth_mode = $urandom_range(0, 3);
            base       = $urandom_range(0, 65531);
            for (int i = 0; i < mesh_size; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_word(read_word());
                    pace();
                end
                send_word(random_load(depth_mode, base, i == mesh_size - 1));
                pace();
            end
            extra = board.kept + $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0)
                extra = $urandom_range(0, board.kept);
            for (int i = 0; i < extra; i++) begin
                send_word(read_word());
                pace();
            end
        end
        drain();

        $display("Sent %0d words: %0d sorts, %0d order entries, %0d dropped loads.",
                 words_sent, board.sorts, board.entries, board.drops);
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
design/bcds_pkg.sv
design/backface_cull_depth_bucket_sort.sv
tb/sv/tb_backface_cull_depth_bucket_sort.sv
